@@ src/gmt_pkg.sv @@
package gmt_pkg;

    localparam int unsigned ID_W   = 32;
    localparam int unsigned PORT_W = 16;
    localparam int unsigned HB_W   = 32;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned TO_W   = 16;
    localparam int unsigned EV_W   = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [1:0] REQ_GOSSIP = 2'd0;
    localparam logic [1:0] REQ_JOIN   = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_PORT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTS_IN = 2'd3;

    localparam logic [EV_W-1:0] EV_STALE        = 3'd0;
    localparam logic [EV_W-1:0] EV_REFRESHED    = 3'd1;
    localparam logic [EV_W-1:0] EV_INSERTED     = 3'd2;
    localparam logic [EV_W-1:0] EV_TOO_OLD      = 3'd3;
    localparam logic [EV_W-1:0] EV_FULL         = 3'd4;
    localparam logic [EV_W-1:0] EV_REMOVED      = 3'd5;
    localparam logic [EV_W-1:0] EV_SWEEP_DONE   = 3'd6;
    localparam logic [EV_W-1:0] EV_NOT_IN_GROUP = 3'd7;

    // classified command handed from front to back
    typedef enum logic [1:0] {
        t_OP_OFFER,
        t_OP_SWEEP,
        t_OP_NOT_IN
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [ID_W-1:0]   id;
        logic [PORT_W-1:0] port;
        logic [HB_W-1:0]   hb;
        logic [TIME_W-1:0] now;
    } t_cmd;

endpackage

@@ src/gmt_ram.sv @@
module gmt_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/gmt_front.sv @@
module gmt_front (
    input  logic [1:0]                 i_req_type,
    input  logic [gmt_pkg::ID_W-1:0]   i_member_id,
    input  logic [gmt_pkg::PORT_W-1:0] i_member_port,
    input  logic [gmt_pkg::HB_W-1:0]   i_offered_heartbeat,
    input  logic [gmt_pkg::TIME_W-1:0] i_cur_time,
    input  logic                       i_accept,
    input  logic                       i_in_group,
    input  logic [gmt_pkg::HB_W-1:0]   i_own_heartbeat,
    output logic                       o_set_group,
    output logic                       o_push,
    output gmt_pkg::t_cmd              o_cmd
);

    gmt_pkg::t_cmd n_cmd;

    // join joins the group and offers own heartbeat
    always_comb begin
        n_cmd.id   = i_member_id;
        n_cmd.port = i_member_port;
        n_cmd.hb   = i_offered_heartbeat;
        n_cmd.now  = i_cur_time;
        n_cmd.op   = gmt_pkg::t_OP_OFFER;
        o_push      = 1'b0;
        o_set_group = 1'b0;
        unique case (i_req_type)
            gmt_pkg::REQ_GOSSIP: begin
                o_push = i_accept;
            end
            gmt_pkg::REQ_JOIN: begin
                n_cmd.hb    = i_own_heartbeat;
                o_push      = i_accept;
                o_set_group = i_accept;
            end
            gmt_pkg::REQ_TICK: begin
                n_cmd.op = i_in_group ? gmt_pkg::t_OP_SWEEP : gmt_pkg::t_OP_NOT_IN;
                o_push   = i_accept;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    assign o_cmd = n_cmd;

endmodule

@@ src/gmt_back.sv @@
module gmt_back #(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_valid,
    input  gmt_pkg::t_cmd                  i_cmd,
    output logic                           o_cmd_pop,
    input  logic [gmt_pkg::ID_W-1:0]       i_self_id,
    input  logic [gmt_pkg::PORT_W-1:0]     i_self_port,
    input  logic [gmt_pkg::TO_W-1:0]       i_timeout,
    output logic                           o_idle,
    output logic                           o_valid,
    output logic [gmt_pkg::EV_W-1:0]       o_event_res,
    output logic [gmt_pkg::ID_W-1:0]       o_out_id,
    output logic [gmt_pkg::PORT_W-1:0]     o_out_port,
    output logic [gmt_pkg::HB_W-1:0]       o_out_heartbeat,
    output logic                           o_announce_add,
    output logic                           o_last,
    output logic [gmt_pkg::HB_W-1:0]       o_own_heartbeat
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = AW + 1;
    localparam int unsigned EW = gmt_pkg::ID_W + gmt_pkg::PORT_W
                               + gmt_pkg::HB_W + gmt_pkg::TIME_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_DECIDE,
        S_SWEEP_RD,
        S_SWEEP_CHK,
        S_DONE
    } t_state;

    t_state r_state;
    gmt_pkg::t_cmd r_cmd;
    logic [CW-1:0] r_idx;
    logic [TABLE_DEPTH-1:0] r_valid_bits;
    logic r_have_free;
    logic [AW-1:0] r_free;
    logic [gmt_pkg::HB_W-1:0] r_own_hb;

    logic r_o_valid;
    logic [gmt_pkg::EV_W-1:0] r_o_ev;
    logic [gmt_pkg::ID_W-1:0] r_o_id;
    logic [gmt_pkg::PORT_W-1:0] r_o_port;
    logic [gmt_pkg::HB_W-1:0] r_o_hb;
    logic r_o_add;
    logic r_o_last;

    logic          we;
    logic [AW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic [AW-1:0] raddr;
    logic [EW-1:0] rdata;

    logic [gmt_pkg::ID_W-1:0]   e_id;
    logic [gmt_pkg::PORT_W-1:0] e_port;
    logic [gmt_pkg::HB_W-1:0]   e_hb;
    logic [gmt_pkg::TIME_W-1:0] e_lh;
    logic [AW-1:0] cur;
    logic [gmt_pkg::TIME_W-1:0] age;
    logic [gmt_pkg::TO_W:0] limit;
    logic [gmt_pkg::HB_W:0] hb_sum;

    assign {e_id, e_port, e_hb, e_lh} = rdata;
    assign cur    = r_idx[AW-1:0];
    assign age    = r_cmd.now - e_lh;
    assign limit  = {i_timeout, 1'b0};
    assign hb_sum = {1'b0, r_cmd.hb} + {{(gmt_pkg::HB_W-gmt_pkg::TO_W+1){1'b0}}, i_timeout};

    gmt_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        we    = 1'b0;
        waddr = cur;
        wdata = {r_cmd.id, r_cmd.port, r_cmd.hb, r_cmd.now};
        raddr = cur;
        if (r_state == S_CHECK && r_valid_bits[cur] && e_id == r_cmd.id
                && e_port == r_cmd.port && r_cmd.hb > e_hb) begin
            we = 1'b1;
        end
        if (r_state == S_DECIDE && hb_sum > {1'b0, r_own_hb} && r_have_free) begin
            we    = 1'b1;
            waddr = r_free;
        end
        if (r_state == S_SWEEP_CHK && r_valid_bits[cur] && e_id == i_self_id) begin
            we    = 1'b1;
            wdata = {e_id, e_port, r_own_hb, r_cmd.now};
        end
    end

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign o_idle    = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid_bits <= '0;
            r_own_hb     <= '0;
            r_o_valid    <= 1'b0;
            r_idx        <= '0;
            r_have_free  <= 1'b0;
        end else begin
            r_o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd       <= i_cmd;
                        r_idx       <= '0;
                        r_have_free <= 1'b0;
                        unique case (i_cmd.op)
                            gmt_pkg::t_OP_OFFER: r_state <= S_READ;
                            gmt_pkg::t_OP_SWEEP: begin
                                r_own_hb <= r_own_hb + 1'b1;
                                r_state  <= S_SWEEP_RD;
                            end
                            default: begin
                                r_o_valid <= 1'b1;
                                r_o_ev    <= gmt_pkg::EV_NOT_IN_GROUP;
                                r_o_id    <= i_self_id;
                                r_o_port  <= i_self_port;
                                r_o_hb    <= r_own_hb;
                                r_o_add   <= 1'b0;
                                r_o_last  <= 1'b1;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_valid_bits[cur] && e_id == r_cmd.id && e_port == r_cmd.port) begin
                        r_o_valid <= 1'b1;
                        r_o_id    <= r_cmd.id;
                        r_o_port  <= r_cmd.port;
                        r_o_add   <= 1'b0;
                        r_o_last  <= 1'b1;
                        if (r_cmd.hb > e_hb) begin
                            r_o_ev <= gmt_pkg::EV_REFRESHED;
                            r_o_hb <= r_cmd.hb;
                        end else begin
                            r_o_ev <= gmt_pkg::EV_STALE;
                            r_o_hb <= e_hb;
                        end
                        r_state <= S_IDLE;
                    end else begin
                        if (!r_valid_bits[cur] && !r_have_free) begin
                            r_have_free <= 1'b1;
                            r_free      <= cur;
                        end
                        r_idx   <= r_idx + 1'b1;
                        r_state <= (r_idx == CW'(TABLE_DEPTH - 1)) ? S_DECIDE : S_READ;
                    end
                end
                S_DECIDE: begin
                    r_o_valid <= 1'b1;
                    r_o_id    <= r_cmd.id;
                    r_o_port  <= r_cmd.port;
                    r_o_hb    <= r_cmd.hb;
                    r_o_add   <= 1'b0;
                    r_o_last  <= 1'b1;
                    if (hb_sum <= {1'b0, r_own_hb}) begin
                        r_o_ev <= gmt_pkg::EV_TOO_OLD;
                    end else if (!r_have_free) begin
                        r_o_ev <= gmt_pkg::EV_FULL;
                    end else begin
                        r_o_ev  <= gmt_pkg::EV_INSERTED;
                        r_o_add <= (r_cmd.id != i_self_id);
                        r_valid_bits[r_free] <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_SWEEP_RD: begin
                    r_state <= S_SWEEP_CHK;
                end
                S_SWEEP_CHK: begin
                    if (r_valid_bits[cur] && e_id != i_self_id
                            && {1'b0, age} > {{(gmt_pkg::TIME_W-gmt_pkg::TO_W){1'b0}}, limit}) begin
                        r_valid_bits[cur] <= 1'b0;
                        r_o_valid <= 1'b1;
                        r_o_ev    <= gmt_pkg::EV_REMOVED;
                        r_o_id    <= e_id;
                        r_o_port  <= e_port;
                        r_o_hb    <= e_hb;
                        r_o_add   <= 1'b0;
                        r_o_last  <= 1'b0;
                    end
                    r_idx   <= r_idx + 1'b1;
                    r_state <= (r_idx == CW'(TABLE_DEPTH - 1)) ? S_DONE : S_SWEEP_RD;
                end
                S_DONE: begin
                    r_o_valid <= 1'b1;
                    r_o_ev    <= gmt_pkg::EV_SWEEP_DONE;
                    r_o_id    <= i_self_id;
                    r_o_port  <= i_self_port;
                    r_o_hb    <= r_own_hb;
                    r_o_add   <= 1'b0;
                    r_o_last  <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_o_valid;
    assign o_event_res     = r_o_ev;
    assign o_out_id        = r_o_id;
    assign o_out_port      = r_o_port;
    assign o_out_heartbeat = r_o_hb;
    assign o_announce_add  = r_o_add;
    assign o_last          = r_o_last;
    assign o_own_heartbeat = r_own_hb;

endmodule

@@ src/gossip_membership_table.sv @@
// gossip or join: the table is read and checked entry by entry, stopping early on a hit, then the insert is decided
// tick: scans every entry, removals come out during the scan, sweep done last (not in group: one not-in-group result)
// throughput: one item at a time, the table scan reads one entry at a time from one ram port
// reset: synchronous active low, clears valid marks, own heartbeat and group flag; no clearing pass
// results are strobed for one cycle by o_valid; the receiver cannot stall
module gossip_membership_table #(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_req_type,
    input  logic [gmt_pkg::ID_W-1:0]       i_member_id,
    input  logic [gmt_pkg::PORT_W-1:0]     i_member_port,
    input  logic [gmt_pkg::HB_W-1:0]       i_offered_heartbeat,
    input  logic [gmt_pkg::TIME_W-1:0]     i_cur_time,
    input  logic                           i_cfg_we,
    input  logic [gmt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gmt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_valid,
    output logic [gmt_pkg::EV_W-1:0]       o_event_res,
    output logic [gmt_pkg::ID_W-1:0]       o_out_id,
    output logic [gmt_pkg::PORT_W-1:0]     o_out_port,
    output logic [gmt_pkg::HB_W-1:0]       o_out_heartbeat,
    output logic                           o_announce_add,
    output logic                           o_last
);

    logic [gmt_pkg::ID_W-1:0]   r_self_id;
    logic [gmt_pkg::PORT_W-1:0] r_self_port;
    logic [gmt_pkg::TO_W-1:0]   r_timeout;
    logic                       r_in_group;

    logic          r_q_valid;
    gmt_pkg::t_cmd r_q_cmd;

    logic          accept;
    logic          push;
    logic          set_group;
    logic          pop;
    logic          back_idle;
    gmt_pkg::t_cmd cmd;
    logic [gmt_pkg::HB_W-1:0] own_hb;

    // one-entry queue between front and back; busy until the back is idle again
    assign busy   = r_q_valid || !back_idle;
    assign accept = start && !busy;

    gmt_front u_front (
        .i_req_type          (i_req_type),
        .i_member_id         (i_member_id),
        .i_member_port       (i_member_port),
        .i_offered_heartbeat (i_offered_heartbeat),
        .i_cur_time          (i_cur_time),
        .i_accept            (accept),
        .i_in_group          (r_in_group),
        .i_own_heartbeat     (own_hb),
        .o_set_group         (set_group),
        .o_push              (push),
        .o_cmd               (cmd)
    );

    gmt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (r_q_valid),
        .i_cmd           (r_q_cmd),
        .o_cmd_pop       (pop),
        .i_self_id       (r_self_id),
        .i_self_port     (r_self_port),
        .i_timeout       (r_timeout),
        .o_idle          (back_idle),
        .o_valid         (o_valid),
        .o_event_res     (o_event_res),
        .o_out_id        (o_out_id),
        .o_out_port      (o_out_port),
        .o_out_heartbeat (o_out_heartbeat),
        .o_announce_add  (o_announce_add),
        .o_last          (o_last),
        .o_own_heartbeat (own_hb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_id   <= '0;
            r_self_port <= '0;
            r_timeout   <= gmt_pkg::TO_W'(20);
            r_in_group  <= 1'b0;
            r_q_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    gmt_pkg::CFG_SELF_ID:   r_self_id   <= i_cfg_data;
                    gmt_pkg::CFG_SELF_PORT: r_self_port <= i_cfg_data[gmt_pkg::PORT_W-1:0];
                    gmt_pkg::CFG_TIMEOUT:   r_timeout   <= i_cfg_data[gmt_pkg::TO_W-1:0];
                    gmt_pkg::CFG_STARTS_IN: r_in_group  <= i_cfg_data[0];
                    default: r_in_group <= r_in_group;
                endcase
            end
            if (set_group) begin
                r_in_group <= 1'b1;
            end
            if (push) begin
                r_q_valid <= 1'b1;
                r_q_cmd   <= cmd;
            end else if (pop) begin
                r_q_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_accept_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> busy)
        else $error("item queued but block not busy");
    a_result_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("non-final result while idle");
    a_join_sets_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        set_group && !i_cfg_we |=> r_in_group)
        else $error("join did not set group flag");
`endif

endmodule
